// ===== rtl/core/i8080s_pkg.sv =====
// i8080s_pkg: shared types and constants for the 8080 subset execute block.
// No dependencies.
package i8080s_pkg;

    localparam int ADDR_BITS_DEF = 16;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] imm_low;
        logic [7:0] imm_high;
        logic [7:0] io_in_data;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  cycles;
        logic [15:0] next_pc;
        logic [7:0]  acc_out;
        logic [7:0]  status_word;
        logic        io_write;
        logic        io_read;
        logic [7:0]  io_port;
        logic [7:0]  io_data;
        logic        unsupported;
    } out_word_t;

    localparam logic [2:0] R_B = 3'd0;
    localparam logic [2:0] R_C = 3'd1;
    localparam logic [2:0] R_D = 3'd2;
    localparam logic [2:0] R_E = 3'd3;
    localparam logic [2:0] R_H = 3'd4;
    localparam logic [2:0] R_L = 3'd5;
    localparam logic [2:0] R_A = 3'd6;

    // memory access class chosen by the front end
    typedef enum logic [2:0] {
        MC_NONE  = 3'd0,
        MC_RD1   = 3'd1,
        MC_WR1   = 3'd2,
        MC_RD2   = 3'd3,
        MC_WR2   = 3'd4
    } mem_class_t;

    typedef struct packed {
        in_word_t   word;
        mem_class_t mclass;
        logic       unsup;
        logic [4:0] cyc;
        logic [1:0] len;
    } dec_word_t;

    function automatic logic even_par(input logic [7:0] v);
        even_par = ~^v;
    endfunction

endpackage

// ===== rtl/core/i8080_subset_execute.sv =====
// Words are queued by the front end and executed by the back end, which registers each result.
// The block takes one word per cycle without memory access while the output is not stalled;
// two-byte accesses use the single memory port in S_RUN and S_SEC, reads wait in S_RDW.
// Reset: registers, SP, PC, flags cleared at once; data memory cleared by a pass over all
// 2^ADDR_BITS addresses after reset, during which no word is taken from the queue.
// Depends on i8080s_pkg, i8080s_front, i8080s_back.
module i8080_subset_execute
    import i8080s_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);
    logic      q_valid, q_pop;
    dec_word_t q_word;

    i8080s_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_word   (q_word)
    );

    i8080s_back #(.ADDR_BITS(ADDR_BITS)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_word    (q_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule

// ===== rtl/core/i8080s_front.sv =====
// i8080s_front: accepts instruction words, classifies them, and queues them.
// Depends on i8080s_pkg.
module i8080s_front
    import i8080s_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      q_valid,
    input  logic      q_pop,
    output dec_word_t q_word
);
    dec_word_t  q_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    dec_word_t  d;
    logic       push;

    always_comb
    begin
        d.word = in_word;
        d.mclass = MC_NONE;
        d.unsup = 1'b0;
        d.cyc = 5'd4;
        d.len = 2'd1;
        case (in_word.command)
            8'h00, 8'h08, 8'h10, 8'h18, 8'h20, 8'h28, 8'h30, 8'h27,
            8'h07, 8'h0f, 8'h17, 8'h1f, 8'h2f, 8'ha7, 8'haf, 8'hfb: ;
            8'h01, 8'h11, 8'h21, 8'h31, 8'hc2, 8'hc3:
            begin
                d.cyc = 5'd10;
                d.len = 2'd3;
            end
            8'h02, 8'h12, 8'h77:
            begin
                d.cyc = 5'd7;
                d.mclass = MC_WR1;
            end
            8'h0a, 8'h1a, 8'h56, 8'h5e, 8'h66, 8'h7e:
            begin
                d.cyc = 5'd7;
                d.mclass = MC_RD1;
            end
            8'h03, 8'h13, 8'h23, 8'h0b, 8'h1b, 8'h2b,
            8'h04, 8'h0c, 8'h14, 8'h1c, 8'h24, 8'h2c,
            8'h05, 8'h0d, 8'h15, 8'h1d, 8'h25, 8'h2d,
            8'h6f, 8'h7a, 8'h7b, 8'h7c, 8'heb: d.cyc = 5'd5;
            8'h06, 8'h0e, 8'h16, 8'h1e, 8'h26, 8'h2e, 8'h3e,
            8'he6, 8'hc6, 8'hfe:
            begin
                d.cyc = 5'd7;
                d.len = 2'd2;
            end
            8'h36:
            begin
                d.cyc = 5'd10;
                d.len = 2'd2;
                d.mclass = MC_WR1;
            end
            8'h09, 8'h19, 8'h29: d.cyc = 5'd10;
            8'h22:
            begin
                d.cyc = 5'd16;
                d.len = 2'd3;
                d.mclass = MC_WR2;
            end
            8'h2a:
            begin
                d.cyc = 5'd16;
                d.len = 2'd3;
                d.mclass = MC_RD2;
            end
            8'h32:
            begin
                d.cyc = 5'd13;
                d.len = 2'd3;
                d.mclass = MC_WR1;
            end
            8'h3a:
            begin
                d.cyc = 5'd13;
                d.len = 2'd3;
                d.mclass = MC_RD1;
            end
            8'hc1, 8'hd1, 8'he1, 8'hf1, 8'hc9:
            begin
                d.cyc = 5'd10;
                d.mclass = MC_RD2;
            end
            8'hc5, 8'hd5, 8'he5, 8'hf5:
            begin
                d.cyc = 5'd11;
                d.mclass = MC_WR2;
            end
            8'hcd:
            begin
                d.cyc = 5'd17;
                d.mclass = MC_WR2;
            end
            8'hd3, 8'hdb:
            begin
                d.cyc = 5'd10;
                d.len = 2'd2;
            end
            default: d.unsup = 1'b1;
        endcase
    end

    assign in_stall = cnt_reg[1];
    assign push = in_valid && !in_stall;
    assign q_valid = cnt_reg != 2'd0;
    assign q_word = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (q_pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + 2'(push) - 2'(q_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push || q_pop) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> cnt_reg != 2'd0) else $error("queue underflow");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
`endif

endmodule

// ===== rtl/core/i8080s_back.sv =====
// i8080s_back: executes queued instructions against registers and data memory.
// Depends on i8080s_pkg.
module i8080s_back
    import i8080s_pkg::*;
#(
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_valid,
    output logic      q_pop,
    input  dec_word_t q_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word
);
    localparam int DEPTH = 1 << ADDR_BITS;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_RUN   = 4'b0010,
        S_SEC   = 4'b0100,
        S_RDW   = 4'b1000
    } st_t;

    logic [7:0]  mem [DEPTH];
    logic [7:0]  rdata_reg;
    st_t         st_reg, st_next;
    logic [ADDR_BITS-1:0] clr_reg;
    logic [7:0]  rf_reg [7];
    logic [7:0]  rf_next [7];
    logic [15:0] sp_reg, sp_next, pc_reg, pc_next;
    logic [4:0]  fl_reg, fl_next;
    logic        ie_reg;
    dec_word_t   cur_reg;
    logic [7:0]  b0_reg;
    out_word_t   ov_reg;
    logic        ovalid_reg;

    logic        mem_we;
    logic [ADDR_BITS-1:0] mem_wa, mem_ra;
    logic [7:0]  mem_wd;
    logic        out_free, fin;
    dec_word_t   w;
    logic [7:0]  op, lo, hi, a, rd0, rd1;
    logic [15:0] a16, hl, pair_op, addr0, addr1, wval;
    logic [2:0]  ph;
    logic [16:0] t17;
    logic [8:0]  t9;
    logic [7:0]  r8, psw;
    out_word_t   o;

    assign out_free = !ovalid_reg || !out_stall;
    assign out_valid = ovalid_reg;
    assign out_word = ov_reg;

    // second phase uses the latched word; first phase the queue head
    assign w = (st_reg == S_RUN) ? q_word : cur_reg;
    assign op = w.word.command;
    assign lo = w.word.imm_low;
    assign hi = w.word.imm_high;
    assign a16 = {hi, lo};
    assign a = rf_reg[R_A];
    assign hl = {rf_reg[R_H], rf_reg[R_L]};
    assign ph = {1'b0, op[5:4], 1'b0} == 4'd0 ? R_B : (op[5:4] == 2'd1 ? R_D : R_H);
    assign pair_op = {rf_reg[ph], rf_reg[ph + 3'd1]};
    assign psw = {fl_reg[4], fl_reg[3], 3'b000, fl_reg[1], 1'b1, fl_reg[0]};

    always_comb
    begin
        case (op)
            8'h02: addr0 = {rf_reg[R_B], rf_reg[R_C]};
            8'h0a: addr0 = {rf_reg[R_B], rf_reg[R_C]};
            8'h12, 8'h1a: addr0 = {rf_reg[R_D], rf_reg[R_E]};
            8'h22, 8'h2a, 8'h32, 8'h3a: addr0 = a16;
            8'hc1, 8'hd1, 8'he1, 8'hf1, 8'hc9: addr0 = sp_reg;
            8'hc5, 8'hd5, 8'he5, 8'hf5, 8'hcd: addr0 = sp_reg - 16'd1;
            default: addr0 = hl;
        endcase
        case (op)
            8'hc5, 8'hd5, 8'he5, 8'hf5, 8'hcd: addr1 = sp_reg - 16'd2;
            default: addr1 = addr0 + 16'd1;
        endcase
        case (op)
            8'hf5: wval = {a, psw};
            8'hcd: wval = pc_reg + 16'd3;
            8'h22: wval = {rf_reg[R_H], rf_reg[R_L]};
            default: wval = pair_op;
        endcase
    end

    assign rd0 = rdata_reg;
    assign rd1 = rdata_reg;

    always_comb
    begin
        st_next = st_reg;
        q_pop = 1'b0;
        fin = 1'b0;
        mem_we = 1'b0;
        mem_wa = addr0[ADDR_BITS-1:0];
        mem_wd = a;
        mem_ra = addr0[ADDR_BITS-1:0];
        case (st_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wa = clr_reg;
                mem_wd = 8'h00;
                if (clr_reg == ADDR_BITS'(DEPTH - 1))
                begin
                    st_next = S_RUN;
                end
            end
            S_RUN:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_word.mclass)
                        MC_NONE:
                        begin
                            fin = 1'b1;
                        end
                        MC_WR1:
                        begin
                            mem_we = 1'b1;
                            mem_wd = (op == 8'h36) ? lo : a;
                            fin = 1'b1;
                        end
                        MC_WR2:
                        begin
                            mem_we = 1'b1;
                            mem_wd = (op == 8'h22) ? wval[7:0] : wval[15:8];
                            st_next = S_SEC;
                        end
                        MC_RD1: st_next = S_RDW;
                        MC_RD2: st_next = S_SEC;
                        default: st_next = S_SEC;
                    endcase
                end
            end
            S_SEC:
            begin
                if (cur_reg.mclass == MC_WR2)
                begin
                    mem_we = 1'b1;
                    mem_wa = addr1[ADDR_BITS-1:0];
                    mem_wd = (op == 8'h22) ? wval[15:8] : wval[7:0];
                    fin = 1'b1;
                    st_next = S_RUN;
                end
                else
                begin
                    mem_ra = addr1[ADDR_BITS-1:0];
                    st_next = S_RDW;
                end
            end
            S_RDW:
            begin
                fin = 1'b1;
                st_next = S_RUN;
            end
            default: st_next = S_RUN;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < 7; i++)
        begin
            rf_next[i] = rf_reg[i];
        end
        sp_next = sp_reg;
        fl_next = fl_reg;
        pc_next = pc_reg + 16'(w.len);
        o = '0;
        o.cycles = w.cyc;
        o.unsupported = w.unsup;
        t17 = {1'b0, hl} + {1'b0, pair_op};
        t9 = {1'b0, a} + {1'b0, lo};
        r8 = 8'h00;
        case (op)
            8'h01, 8'h11, 8'h21:
            begin
                rf_next[ph] = hi;
                rf_next[ph + 3'd1] = lo;
            end
            8'h31: sp_next = a16;
            8'h0a, 8'h1a, 8'h7e, 8'h3a: rf_next[R_A] = rd0;
            8'h56: rf_next[R_D] = rd0;
            8'h5e: rf_next[R_E] = rd0;
            8'h66: rf_next[R_H] = rd0;
            8'h03, 8'h13, 8'h23:
            begin
                {rf_next[ph], rf_next[ph + 3'd1]} = pair_op + 16'd1;
            end
            8'h0b, 8'h1b, 8'h2b:
            begin
                {rf_next[ph], rf_next[ph + 3'd1]} = pair_op - 16'd1;
            end
            8'h04, 8'h0c, 8'h14, 8'h1c, 8'h24, 8'h2c,
            8'h05, 8'h0d, 8'h15, 8'h1d, 8'h25, 8'h2d:
            begin
                r8 = op[0] ? rf_reg[op[5:3]] - 8'd1 : rf_reg[op[5:3]] + 8'd1;
                rf_next[op[5:3]] = r8;
                fl_next[4] = r8[7];
                fl_next[3] = r8 == 8'h00;
                fl_next[1] = even_par(r8);
            end
            8'h06, 8'h0e, 8'h16, 8'h1e, 8'h26, 8'h2e: rf_next[op[5:3]] = lo;
            8'h3e: rf_next[R_A] = lo;
            8'h07:
            begin
                fl_next[0] = a[7];
                rf_next[R_A] = {a[6:0], a[7]};
            end
            8'h0f:
            begin
                fl_next[0] = a[0];
                rf_next[R_A] = {a[0], a[7:1]};
            end
            8'h17:
            begin
                fl_next[0] = a[7];
                rf_next[R_A] = {a[6:0], fl_reg[0]};
            end
            8'h1f:
            begin
                fl_next[0] = a[0];
                rf_next[R_A] = {fl_reg[0], a[7:1]};
            end
            8'h09, 8'h19, 8'h29:
            begin
                {rf_next[R_H], rf_next[R_L]} = t17[15:0];
                fl_next[0] = t17[16];
            end
            8'h2a:
            begin
                rf_next[R_L] = b0_reg;
                rf_next[R_H] = rd1;
            end
            8'h2f: rf_next[R_A] = ~a;
            8'h6f: rf_next[R_L] = a;
            8'h7a: rf_next[R_A] = rf_reg[R_D];
            8'h7b: rf_next[R_A] = rf_reg[R_E];
            8'h7c: rf_next[R_A] = rf_reg[R_H];
            8'ha7, 8'haf, 8'he6, 8'hc6, 8'hfe:
            begin
                case (op)
                    8'ha7: r8 = a;
                    8'he6: r8 = a & lo;
                    8'hc6: r8 = t9[7:0];
                    8'hfe: r8 = a - lo;
                    default: r8 = 8'h00;
                endcase
                if (op != 8'hfe)
                begin
                    rf_next[R_A] = r8;
                end
                fl_next[4] = r8[7];
                fl_next[3] = r8 == 8'h00;
                fl_next[1] = even_par(r8);
                fl_next[0] = (op == 8'hc6) ? t9[8] : ((op == 8'hfe) ? (a < lo) : 1'b0);
            end
            8'hc1, 8'hd1, 8'he1:
            begin
                rf_next[ph] = rd1;
                rf_next[ph + 3'd1] = b0_reg;
                sp_next = sp_reg + 16'd2;
            end
            8'hf1:
            begin
                rf_next[R_A] = rd1;
                fl_next = {b0_reg[7], b0_reg[6], 1'b0, b0_reg[2], b0_reg[0]};
                sp_next = sp_reg + 16'd2;
            end
            8'hc5, 8'hd5, 8'he5, 8'hf5: sp_next = sp_reg - 16'd2;
            8'hc2:
            begin
                if (!fl_reg[3])
                begin
                    pc_next = a16;
                end
            end
            8'hc3: pc_next = a16;
            8'hcd:
            begin
                sp_next = sp_reg - 16'd2;
                pc_next = a16;
            end
            8'hc9:
            begin
                pc_next = {rd1, b0_reg};
                sp_next = sp_reg + 16'd2;
            end
            8'hd3:
            begin
                o.io_write = 1'b1;
                o.io_port = lo;
                o.io_data = a;
            end
            8'hdb:
            begin
                rf_next[R_A] = w.word.io_in_data;
                o.io_read = 1'b1;
                o.io_port = lo;
            end
            8'heb:
            begin
                rf_next[R_D] = rf_reg[R_H];
                rf_next[R_E] = rf_reg[R_L];
                rf_next[R_H] = rf_reg[R_D];
                rf_next[R_L] = rf_reg[R_E];
            end
            default: ;
        endcase
        fl_next[2] = 1'b0;
        o.next_pc = pc_next;
        o.acc_out = rf_next[R_A];
        o.status_word = {fl_next[4], fl_next[3], 3'b000, fl_next[1], 1'b1, fl_next[0]};
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rdata_reg <= mem[mem_ra];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_word;
        end
        if (st_reg == S_SEC)
        begin
            b0_reg <= rdata_reg;
        end
        if (fin)
        begin
            ov_reg <= o;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= S_CLEAR;
            clr_reg <= '0;
            for (int i = 0; i < 7; i++)
            begin
                rf_reg[i] <= 8'h00;
            end
            sp_reg <= 16'h0000;
            pc_reg <= 16'h0000;
            fl_reg <= 5'h00;
            ie_reg <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            clr_reg <= clr_reg + 1'b1;
            if (fin)
            begin
                for (int i = 0; i < 7; i++)
                begin
                    rf_reg[i] <= rf_next[i];
                end
                sp_reg <= sp_next;
                pc_reg <= pc_next;
                fl_reg <= fl_next;
                if (op == 8'hfb)
                begin
                    ie_reg <= 1'b1;
                end
                ovalid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    a_fin_room: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> !ovalid_reg || !out_stall || (st_reg != S_RUN))
        else $error("result overwritten");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        ovalid_reg && out_stall |=> ovalid_reg && $stable(ov_reg))
        else $error("stalled result changed");
    a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_CLEAR |-> !q_pop && !fin) else $error("work during clear");
    a_ie_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        ie_reg |=> ie_reg) else $error("interrupt enable dropped");
`endif

endmodule

// ===== dv/i8080_subset_execute_test.sv =====
// Testbench for i8080_subset_execute: drives instruction words, predicts every result
// with a behavioral model of the 8080 subset and checks each output word field by field.
// Depends on i8080s_pkg and the i8080_subset_execute RTL.
`timescale 1ns / 1ps

module i8080_subset_execute_test;
    import i8080s_pkg::*;

    localparam int AW = 16;
    localparam int WATCHDOG = 200000;

    // flag bit positions inside the internal flag register
    localparam logic [4:0] FL_C = 5'h01;
    localparam logic [4:0] FL_P = 5'h02;
    localparam logic [4:0] FL_Z = 5'h08;
    localparam logic [4:0] FL_S = 5'h10;

    localparam logic [7:0] OP_NOP = 8'h00, OP_DAA = 8'h27;
    localparam logic [7:0] OP_LXI_B = 8'h01, OP_LXI_D = 8'h11, OP_LXI_H = 8'h21;
    localparam logic [7:0] OP_LXI_SP = 8'h31;
    localparam logic [7:0] OP_STAX_B = 8'h02, OP_STAX_D = 8'h12;
    localparam logic [7:0] OP_LDAX_B = 8'h0a, OP_LDAX_D = 8'h1a;
    localparam logic [7:0] OP_MVI_M = 8'h36, OP_MVI_A = 8'h3e;
    localparam logic [7:0] OP_RLC = 8'h07, OP_RRC = 8'h0f, OP_RAL = 8'h17, OP_RAR = 8'h1f;
    localparam logic [7:0] OP_SHLD = 8'h22, OP_LHLD = 8'h2a, OP_CMA = 8'h2f;
    localparam logic [7:0] OP_STA = 8'h32, OP_LDA = 8'h3a;
    localparam logic [7:0] OP_MOV_DM = 8'h56, OP_MOV_EM = 8'h5e, OP_MOV_HM = 8'h66;
    localparam logic [7:0] OP_MOV_LA = 8'h6f, OP_MOV_MA = 8'h77;
    localparam logic [7:0] OP_MOV_AD = 8'h7a, OP_MOV_AE = 8'h7b, OP_MOV_AH = 8'h7c;
    localparam logic [7:0] OP_MOV_AM = 8'h7e;
    localparam logic [7:0] OP_ANA_A = 8'ha7, OP_XRA_A = 8'haf, OP_ANI = 8'he6;
    localparam logic [7:0] OP_ADI = 8'hc6, OP_CPI = 8'hfe;
    localparam logic [7:0] OP_POP_B = 8'hc1, OP_POP_D = 8'hd1, OP_POP_H = 8'he1;
    localparam logic [7:0] OP_POP_PSW = 8'hf1;
    localparam logic [7:0] OP_PUSH_B = 8'hc5, OP_PUSH_D = 8'hd5, OP_PUSH_H = 8'he5;
    localparam logic [7:0] OP_PUSH_PSW = 8'hf5;
    localparam logic [7:0] OP_JNZ = 8'hc2, OP_JMP = 8'hc3, OP_CALL = 8'hcd, OP_RET = 8'hc9;
    localparam logic [7:0] OP_OUT = 8'hd3, OP_IN = 8'hdb, OP_XCHG = 8'heb, OP_EI = 8'hfb;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    in_word_t  in_word;
    logic      out_valid;
    logic      out_stall;
    out_word_t out_word;

    i8080_subset_execute dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

    // shadow machine state
    logic [7:0]  cpu_reg [7];
    logic [15:0] cpu_sp;
    logic [15:0] cpu_pc;
    logic [4:0]  cpu_flags;
    logic        cpu_ie;
    logic [7:0]  cpu_mem [logic [AW-1:0]];

    out_word_t pending_results [$];
    int        err_count;
    int        sent_count;
    int        checked_count;
    int        idle_cycles;
    bit        idle_enable;
    bit        hold_off;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic logic [7:0] mem_read(input logic [15:0] addr);
        logic [AW-1:0] a;
        a = addr[AW-1:0];
        return cpu_mem.exists(a) ? cpu_mem[a] : 8'h00;
    endfunction

    function automatic void mem_write(input logic [15:0] addr, input logic [7:0] v);
        cpu_mem[addr[AW-1:0]] = v;
    endfunction

    function automatic logic [15:0] pair_of(input int hi);
        return {cpu_reg[hi], cpu_reg[hi+1]};
    endfunction

    function automatic void pair_load(input int hi, input logic [15:0] v);
        cpu_reg[hi]   = v[15:8];
        cpu_reg[hi+1] = v[7:0];
    endfunction

    function automatic void update_szp(input logic [7:0] v);
        cpu_flags = cpu_flags & (FL_C | 5'h04);
        if (~^v) cpu_flags |= FL_P;
        if (v == 8'h00) cpu_flags |= FL_Z;
        if (v[7]) cpu_flags |= FL_S;
    endfunction

    function automatic void update_carry(input logic c);
        cpu_flags = (cpu_flags & ~FL_C) | (c ? FL_C : 5'h00);
    endfunction

    function automatic logic [7:0] psw_of();
        return {cpu_flags[4], cpu_flags[3], 3'b000, cpu_flags[1], 1'b1, cpu_flags[0]};
    endfunction

    function automatic void stack_push(input logic [15:0] v);
        mem_write(cpu_sp - 16'd1, v[15:8]);
        mem_write(cpu_sp - 16'd2, v[7:0]);
        cpu_sp = cpu_sp - 16'd2;
    endfunction

    function automatic logic [15:0] stack_pop();
        logic [15:0] v;
        v = {mem_read(cpu_sp + 16'd1), mem_read(cpu_sp)};
        cpu_sp = cpu_sp + 16'd2;
        return v;
    endfunction

    function automatic void machine_reset();
        foreach (cpu_reg[i]) cpu_reg[i] = 8'h00;
        cpu_sp = 16'h0000;
        cpu_pc = 16'h0000;
        cpu_flags = 5'h00;
        cpu_ie = 1'b0;
        cpu_mem.delete();
    endfunction

    function automatic out_word_t execute_word(input in_word_t w);
        out_word_t   r;
        logic [7:0]  op;
        logic [7:0]  lo;
        logic [7:0]  acc;
        logic [15:0] a16;
        logic [15:0] npc;
        logic [16:0] sum;
        logic [4:0]  cyc;
        logic [1:0]  len;
        logic        jumped;
        logic        wr_io;
        logic        rd_io;
        logic        unsup;
        logic        cin;
        int          hp;
        int          rr;
        op = w.command;
        lo = w.imm_low;
        acc = cpu_reg[R_A];
        a16 = {w.imm_high, w.imm_low};
        npc = 16'h0000;
        cyc = 5'd4;
        len = 2'd1;
        jumped = 1'b0;
        wr_io = 1'b0;
        rd_io = 1'b0;
        unsup = 1'b0;
        hp = int'(op[5:4]) * 2;
        rr = int'(op[5:3]);
        case (op)
            OP_NOP, 8'h08, 8'h10, 8'h18, 8'h20, 8'h28, 8'h30, OP_DAA: ;
            OP_LXI_B, OP_LXI_D, OP_LXI_H:
            begin
                pair_load(hp, a16);
                cyc = 5'd10;
                len = 2'd3;
            end
            OP_LXI_SP:
            begin
                cpu_sp = a16;
                cyc = 5'd10;
                len = 2'd3;
            end
            OP_STAX_B: begin mem_write(pair_of(R_B), acc); cyc = 5'd7; end
            OP_STAX_D: begin mem_write(pair_of(R_D), acc); cyc = 5'd7; end
            OP_LDAX_B: begin cpu_reg[R_A] = mem_read(pair_of(R_B)); cyc = 5'd7; end
            OP_LDAX_D: begin cpu_reg[R_A] = mem_read(pair_of(R_D)); cyc = 5'd7; end
            8'h03, 8'h13, 8'h23: begin pair_load(hp, pair_of(hp) + 16'd1); cyc = 5'd5; end
            8'h0b, 8'h1b, 8'h2b: begin pair_load(hp, pair_of(hp) - 16'd1); cyc = 5'd5; end
            8'h04, 8'h0c, 8'h14, 8'h1c, 8'h24, 8'h2c:
            begin
                cpu_reg[rr] = cpu_reg[rr] + 8'd1;
                update_szp(cpu_reg[rr]);
                cyc = 5'd5;
            end
            8'h05, 8'h0d, 8'h15, 8'h1d, 8'h25, 8'h2d:
            begin
                cpu_reg[rr] = cpu_reg[rr] - 8'd1;
                update_szp(cpu_reg[rr]);
                cyc = 5'd5;
            end
            8'h06, 8'h0e, 8'h16, 8'h1e, 8'h26, 8'h2e, OP_MVI_A:
            begin
                cpu_reg[rr == 7 ? R_A : rr] = lo;
                cyc = 5'd7;
                len = 2'd2;
            end
            OP_MVI_M: begin mem_write(pair_of(R_H), lo); cyc = 5'd10; len = 2'd2; end
            OP_RLC: begin update_carry(acc[7]); cpu_reg[R_A] = {acc[6:0], acc[7]}; end
            OP_RRC: begin update_carry(acc[0]); cpu_reg[R_A] = {acc[0], acc[7:1]}; end
            OP_RAL:
            begin
                cin = cpu_flags[0];
                update_carry(acc[7]);
                cpu_reg[R_A] = {acc[6:0], cin};
            end
            OP_RAR:
            begin
                cin = cpu_flags[0];
                update_carry(acc[0]);
                cpu_reg[R_A] = {cin, acc[7:1]};
            end
            8'h09, 8'h19, 8'h29:
            begin
                sum = {1'b0, pair_of(R_H)} + {1'b0, pair_of(hp)};
                pair_load(R_H, sum[15:0]);
                update_carry(sum[16]);
                cyc = 5'd10;
            end
            OP_SHLD:
            begin
                mem_write(a16, cpu_reg[R_L]);
                mem_write(a16 + 16'd1, cpu_reg[R_H]);
                cyc = 5'd16;
                len = 2'd3;
            end
            OP_LHLD:
            begin
                cpu_reg[R_L] = mem_read(a16);
                cpu_reg[R_H] = mem_read(a16 + 16'd1);
                cyc = 5'd16;
                len = 2'd3;
            end
            OP_CMA: cpu_reg[R_A] = ~acc;
            OP_STA: begin mem_write(a16, acc); cyc = 5'd13; len = 2'd3; end
            OP_LDA: begin cpu_reg[R_A] = mem_read(a16); cyc = 5'd13; len = 2'd3; end
            OP_MOV_DM: begin cpu_reg[R_D] = mem_read(pair_of(R_H)); cyc = 5'd7; end
            OP_MOV_EM: begin cpu_reg[R_E] = mem_read(pair_of(R_H)); cyc = 5'd7; end
            OP_MOV_HM: begin cpu_reg[R_H] = mem_read(pair_of(R_H)); cyc = 5'd7; end
            OP_MOV_LA: begin cpu_reg[R_L] = acc; cyc = 5'd5; end
            OP_MOV_MA: begin mem_write(pair_of(R_H), acc); cyc = 5'd7; end
            OP_MOV_AD: begin cpu_reg[R_A] = cpu_reg[R_D]; cyc = 5'd5; end
            OP_MOV_AE: begin cpu_reg[R_A] = cpu_reg[R_E]; cyc = 5'd5; end
            OP_MOV_AH: begin cpu_reg[R_A] = cpu_reg[R_H]; cyc = 5'd5; end
            OP_MOV_AM: begin cpu_reg[R_A] = mem_read(pair_of(R_H)); cyc = 5'd7; end
            OP_ANA_A: begin update_szp(acc); update_carry(1'b0); end
            OP_XRA_A: begin cpu_reg[R_A] = 8'h00; update_szp(8'h00); update_carry(1'b0); end
            OP_ANI:
            begin
                cpu_reg[R_A] = acc & lo;
                update_szp(cpu_reg[R_A]);
                update_carry(1'b0);
                cyc = 5'd7;
                len = 2'd2;
            end
            OP_ADI:
            begin
                sum = {9'd0, acc} + {9'd0, lo};
                cpu_reg[R_A] = sum[7:0];
                update_szp(sum[7:0]);
                update_carry(sum[8]);
                cyc = 5'd7;
                len = 2'd2;
            end
            OP_CPI:
            begin
                update_szp(acc - lo);
                update_carry(acc < lo);
                cyc = 5'd7;
                len = 2'd2;
            end
            OP_POP_B, OP_POP_D, OP_POP_H: begin pair_load(hp, stack_pop()); cyc = 5'd10; end
            OP_POP_PSW:
            begin
                a16 = stack_pop();
                cpu_reg[R_A] = a16[15:8];
                cpu_flags = {a16[7], a16[6], 1'b0, a16[2], a16[0]};
                cyc = 5'd10;
            end
            OP_PUSH_B, OP_PUSH_D, OP_PUSH_H: begin stack_push(pair_of(hp)); cyc = 5'd11; end
            OP_PUSH_PSW: begin stack_push({acc, psw_of()}); cyc = 5'd11; end
            OP_JNZ:
            begin
                cyc = 5'd10;
                len = 2'd3;
                if (!cpu_flags[3])
                begin
                    npc = a16;
                    jumped = 1'b1;
                end
            end
            OP_JMP: begin cyc = 5'd10; npc = a16; jumped = 1'b1; end
            OP_CALL:
            begin
                stack_push(cpu_pc + 16'd3);
                cyc = 5'd17;
                npc = a16;
                jumped = 1'b1;
            end
            OP_RET: begin npc = stack_pop(); cyc = 5'd10; jumped = 1'b1; end
            OP_OUT: begin wr_io = 1'b1; cyc = 5'd10; len = 2'd2; end
            OP_IN: begin cpu_reg[R_A] = w.io_in_data; rd_io = 1'b1; cyc = 5'd10; len = 2'd2; end
            OP_XCHG:
            begin
                a16 = pair_of(R_D);
                pair_load(R_D, pair_of(R_H));
                pair_load(R_H, a16);
                cyc = 5'd5;
            end
            OP_EI: cpu_ie = 1'b1;
            default: unsup = 1'b1;
        endcase
        if (!jumped) npc = cpu_pc + 16'(len);
        cpu_pc = npc;
        cpu_flags[2] = 1'b0;
        r.cycles = cyc;
        r.next_pc = npc;
        r.acc_out = cpu_reg[R_A];
        r.status_word = psw_of();
        r.io_write = wr_io;
        r.io_read = rd_io;
        r.io_port = (wr_io || rd_io) ? lo : 8'h00;
        r.io_data = wr_io ? acc : 8'h00;
        r.unsupported = unsup;
        return r;
    endfunction

    task automatic send_word(input logic [7:0] op, input logic [7:0] lo, input logic [7:0] hi,
                             input logic [7:0] din);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 5);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= '{command: op, imm_low: lo, imm_high: hi, io_in_data: din};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results.push_back(execute_word('{command: op, imm_low: lo, imm_high: hi,
                                                io_in_data: din}));
        sent_count++;
    endtask

    task automatic drop_valid();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // result checker
    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result word next_pc=%h", out_word.next_pc);
                err_count++;
            end
            else
            begin
                e = pending_results.pop_front();
                checked_count++;
                if (out_word.cycles !== e.cycles)
                begin
                    $error("cycles exp %0d got %0d", e.cycles, out_word.cycles);
                    err_count++;
                end
                if (out_word.next_pc !== e.next_pc)
                begin
                    $error("next_pc exp %h got %h", e.next_pc, out_word.next_pc);
                    err_count++;
                end
                if (out_word.acc_out !== e.acc_out)
                begin
                    $error("acc_out exp %h got %h", e.acc_out, out_word.acc_out);
                    err_count++;
                end
                if (out_word.status_word !== e.status_word)
                begin
                    $error("status_word exp %h got %h", e.status_word, out_word.status_word);
                    err_count++;
                end
                if (out_word.io_write !== e.io_write)
                begin
                    $error("io_write exp %b got %b", e.io_write, out_word.io_write);
                    err_count++;
                end
                if (out_word.io_read !== e.io_read)
                begin
                    $error("io_read exp %b got %b", e.io_read, out_word.io_read);
                    err_count++;
                end
                if (out_word.io_port !== e.io_port)
                begin
                    $error("io_port exp %h got %h", e.io_port, out_word.io_port);
                    err_count++;
                end
                if (out_word.io_data !== e.io_data)
                begin
                    $error("io_data exp %h got %h", e.io_data, out_word.io_data);
                    err_count++;
                end
                if (out_word.unsupported !== e.unsupported)
                begin
                    $error("unsupported exp %b got %b", e.unsupported, out_word.unsupported);
                    err_count++;
                end
            end
        end
    end

    // receiver stall: random bursts, or one long hold-off
    initial
    begin
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (300) @(posedge clk);
                out_stall <= 1'b0;
                hold_off = 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 5);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any accepted word; covers the memory clear pass
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] OP_INR_ALT(input int i);
        return (i % 2) ? OP_PUSH_B : OP_POP_D;
    endfunction

    task automatic test_directed();
        send_word(OP_NOP, 8'h00, 8'h00, 8'h00);
        send_word(OP_LXI_SP, 8'h00, 8'h00, 8'h00);
        send_word(OP_MVI_A, 8'hff, 8'h00, 8'h00);
        send_word(OP_ADI, 8'h01, 8'h00, 8'h00);
        send_word(OP_CPI, 8'hff, 8'h00, 8'h00);
        send_word(OP_LXI_H, 8'hff, 8'hff, 8'h00);
        send_word(OP_SHLD, 8'hff, 8'hff, 8'h00);
        send_word(OP_LHLD, 8'hfe, 8'hff, 8'h00);
        send_word(OP_DAA, 8'h00, 8'h00, 8'h00);
        send_word(OP_PUSH_PSW, 8'h00, 8'h00, 8'h00);
        send_word(OP_POP_PSW, 8'h00, 8'h00, 8'h00);
        send_word(8'h1b, 8'h00, 8'h00, 8'h00);
        send_word(8'h2b, 8'h00, 8'h00, 8'h00);
        send_word(OP_MOV_LA, 8'h00, 8'h00, 8'h00);
        send_word(OP_IN, 8'h80, 8'h00, 8'hff);
        send_word(OP_OUT, 8'hff, 8'h00, 8'h00);
        send_word(OP_XRA_A, 8'h00, 8'h00, 8'h00);
        send_word(OP_JNZ, 8'h34, 8'h12, 8'h00);
        send_word(OP_CALL, 8'hff, 8'hff, 8'h00);
        send_word(OP_RET, 8'h00, 8'h00, 8'h00);
        send_word(OP_EI, 8'h00, 8'h00, 8'h00);
        send_word(8'hff, 8'hff, 8'hff, 8'hff);
        send_word(OP_JMP, 8'h00, 8'h00, 8'h00);
        drop_valid();
    endtask

    // random opcodes with small address windows so reads hit written bytes
    task automatic test_random(input int count);
        logic [7:0] op;
        logic [7:0] hi;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) == 0)
                op = rand_byte();
            else
                op = 8'($urandom_range(0, 255));
            while ($urandom_range(0, 3) != 0 && op > 8'h3f && op < 8'ha0 &&
                   !(op inside {OP_MOV_DM, OP_MOV_EM, OP_MOV_HM, OP_MOV_LA, OP_MOV_MA,
                                OP_MOV_AD, OP_MOV_AE, OP_MOV_AH, OP_MOV_AM}))
                op = 8'($urandom_range(0, 255));
            hi = ($urandom_range(0, 3) == 0) ? rand_byte() : 8'($urandom_range(0, 1));
            send_word(op, rand_byte(), hi, rand_byte());
        end
        drop_valid();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 40; i++)
            send_word(OP_INR_ALT(i), rand_byte(), rand_byte(), rand_byte());
        drop_valid();
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (pending_results.size() != 0) @(posedge clk);
        while (guard < 20)
        begin
            @(posedge clk);
            guard++;
        end
    endtask

    initial
    begin
        machine_reset();
        err_count = 0;
        sent_count = 0;
        checked_count = 0;
        idle_enable = 1'b1;
        hold_off = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_word <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(1400);
        idle_enable = 1'b0;
        test_random(350);
        wait_drained();
        $display("Ran %0d instruction words, %0d results checked, incl. stack, memory, I/O",
                 sent_count, checked_count);
        $display("and unsupported opcodes, random idling and a long output hold-off.");
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
